### hdl/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
package mlfq_pkg;

    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_SCHED = 3'd1,
        MODE_ADMIT = 3'd2,
        MODE_YIELD = 3'd3,
        MODE_SLEEP = 3'd4,
        MODE_WAKE  = 3'd5,
        MODE_SETLV = 3'd6,
        MODE_FREE  = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        RES_OK    = 3'd0,
        RES_NONE  = 3'd1,
        RES_WRONG = 3'd2,
        RES_LEVEL = 3'd3,
        RES_BUSY  = 3'd4
    } t_res;

    typedef enum logic [1:0] {
        SST_FREE     = 2'd0,
        SST_RUNNABLE = 2'd1,
        SST_RUNNING  = 2'd2,
        SST_SLEEPING = 2'd3
    } t_sst;

    typedef struct packed {
        t_sst        status;
        logic [1:0]  level;
        logic [7:0]  slice;
        logic [31:0] last_ran;
        logic [7:0]  chan;
    } t_entry;

    localparam logic [2:0] REG_BOOST = 3'd0;
    localparam logic [2:0] REG_AGING = 3'd1;
    localparam logic [2:0] REG_AGETH = 3'd2;
    localparam logic [2:0] REG_LIM0  = 3'd3;
    localparam logic [2:0] REG_LIM1  = 3'd4;
    localparam logic [2:0] REG_LIM2  = 3'd5;
    localparam logic [2:0] REG_LIM3  = 3'd6;

    localparam logic [15:0] BOOST_RST = 16'd100;
    localparam logic [15:0] AGING_RST = 16'd20;
    localparam logic [15:0] AGETH_RST = 16'd20;
    localparam logic [7:0]  LIM0_RST  = 8'd2;
    localparam logic [7:0]  LIM1_RST  = 8'd4;
    localparam logic [7:0]  LIM2_RST  = 8'd8;
    localparam logic [7:0]  LIM3_RST  = 8'd16;

endpackage

### hdl/mlfq_scheduler_with_boost_and_aging.sv
// Multilevel feedback queue scheduler: sequencer around the slot table.
//
// Use: an item (mode, slot, level, channel) is transferred on the input
// channel when i_in_valid is high and o_in_stall is low. Every item gives
// exactly one result on the output channel, transferred when o_out_valid is
// high and i_out_stall is low. Configuration must be written over the APB
// port only while the block is idle; the block does not enforce this. Reads
// return the register values. Items answered without touching the table (a
// tick or yield with nothing running, a rejected level or slot, a schedule
// while a slot runs) go from S_IDLE straight to S_DONE; items on one slot
// pass S_EXEC, then S_DONE. Schedule and wake walk the whole table in S_SCAN,
// one slot per cycle; a schedule that picks a slot then passes S_PICK.
// One item is worked on at a time; o_in_stall stays high until its result
// sits in the output register, so the next item can be transferred while
// that result still waits. A stalled receiver holds the result and, once
// the next item is done, holds the block.
// Reset clears all slots to free at once (valid bits), zeroes the time
// counters and loads the default configuration.
module mlfq_scheduler_with_boost_and_aging #(
    parameter int SLOT_COUNT  = 64,
    parameter int LEVEL_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [5:0]  i_slot,
    input  logic [1:0]  i_level,
    input  logic [7:0]  i_channel,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_chosen_slot,
    output logic [1:0]  o_chosen_level,
    output logic [7:0]  o_chosen_slice,
    output logic        o_demoted,
    output logic [6:0]  o_woken_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mlfq_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam logic [IW-1:0] LAST_IX = IW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_SCAN, S_PICK, S_DONE
    } t_state;

    t_state      r_state;
    t_mode       r_mode;
    logic [5:0]  r_slot;
    logic [1:0]  r_lvl;
    logic [7:0]  r_chan;

    logic [15:0] r_boost_int, r_aging_int, r_age_thr;
    logic [7:0]  r_lim [4];

    logic [31:0] r_now, r_last_boost, r_last_aging;
    logic        r_run_vld;
    logic [IW-1:0] r_run_slot;

    logic [IW-1:0] r_idx;
    logic        r_bdue, r_adue, r_found;
    logic [IW-1:0] r_best_ix;
    t_entry      r_best;
    logic [6:0]  r_woke;

    t_res        r_res_st;
    logic [5:0]  r_res_slot;
    logic [1:0]  r_res_lvl;
    logic [7:0]  r_res_slc;
    logic        r_res_dem;
    logic [6:0]  r_res_woke;

    logic        r_out_vld;
    t_res        r_o_st;
    logic [5:0]  r_o_slot;
    logic [1:0]  r_o_lvl;
    logic [7:0]  r_o_slc;
    logic        r_o_dem;
    logic [6:0]  r_o_woke;

    logic        w_accept, w_in_range, w_lvl_bad, w_match, w_take, w_wake_hit;
    logic [IW-1:0] w_slot_ix, w_rd_addr, w_wr_addr;
    t_entry      w_ent, w_tk_ent, w_sc_ent, w_wr_data, w_pick_ent;
    logic [7:0]  w_tk_inc;
    logic        w_tk_exp, w_wr_en, w_wr_keep;
    logic [6:0]  w_woke_nx;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_slot_ix  = IW'(i_slot);
    assign w_in_range = 32'(i_slot) < SLOT_COUNT;
    assign w_lvl_bad  = 32'(i_level) >= LEVEL_COUNT;
    assign w_match    = r_run_vld && (r_run_slot == IW'(r_slot));

    mlfq_tbl #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ent),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_wr_keep (w_wr_keep)
    );

    // Charge of the running slot on a tick.
    always_comb begin
        w_tk_ent = w_ent;
        w_tk_inc = (w_ent.slice == 8'hFF) ? w_ent.slice : w_ent.slice + 8'd1;
        w_tk_exp = w_tk_inc >= r_lim[w_ent.level];
        w_tk_ent.slice = w_tk_exp ? 8'd0 : w_tk_inc;
        if (w_tk_exp && (32'(w_ent.level) < LEVEL_COUNT - 1)) begin
            w_tk_ent.level = w_ent.level + 2'd1;
        end
    end

    // One slot of a schedule or wake pass.
    always_comb begin
        w_sc_ent   = w_ent;
        w_wake_hit = 1'b0;
        if (r_mode == MODE_WAKE) begin
            w_wake_hit = (w_ent.status == SST_SLEEPING) && (w_ent.chan == r_chan);
            if (w_wake_hit) begin
                w_sc_ent.status = SST_RUNNABLE;
            end
        end else begin
            if (r_bdue && w_ent.status != SST_FREE) begin
                w_sc_ent.level    = 2'd0;
                w_sc_ent.slice    = 8'd0;
                w_sc_ent.last_ran = r_now;
            end
            // A boosted slot sits at level zero, so aging never touches it too.
            if (r_adue && w_sc_ent.status == SST_RUNNABLE && w_sc_ent.level != 2'd0 &&
                (r_now - w_sc_ent.last_ran) >= {16'd0, r_age_thr}) begin
                w_sc_ent.level    = w_sc_ent.level - 2'd1;
                w_sc_ent.slice    = 8'd0;
                w_sc_ent.last_ran = r_now;
            end
        end
        w_take = (r_mode == MODE_SCHED) && (w_sc_ent.status == SST_RUNNABLE) &&
                 (!r_found || w_sc_ent.level < r_best.level);
        w_woke_nx = (w_wake_hit && r_woke != 7'h7F) ? r_woke + 7'd1 : r_woke;
        w_pick_ent = r_best;
        w_pick_ent.status   = SST_RUNNING;
        w_pick_ent.last_ran = r_now;
    end

    // Table read address and write port.
    always_comb begin
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = IW'(r_slot);
        w_wr_data = w_ent;
        w_wr_keep = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_mode == MODE_TICK || i_mode == MODE_YIELD) begin
                    w_rd_addr = r_run_slot;
                end else if (i_mode != MODE_SCHED && i_mode != MODE_WAKE) begin
                    w_rd_addr = w_slot_ix;
                end
            end
            S_EXEC: begin
                case (r_mode)
                    MODE_TICK: begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_run_slot;
                        w_wr_data = w_tk_ent;
                    end
                    MODE_YIELD: begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_run_slot;
                        w_wr_data.status = SST_RUNNABLE;
                    end
                    MODE_ADMIT: begin
                        w_wr_en   = (w_ent.status == SST_FREE);
                        w_wr_data = '{status: SST_RUNNABLE, level: r_lvl, slice: 8'd0,
                                      last_ran: r_now, chan: 8'd0};
                    end
                    MODE_SLEEP: begin
                        w_wr_en   = (w_ent.status == SST_RUNNING);
                        w_wr_data.status = SST_SLEEPING;
                        w_wr_data.slice  = 8'd0;
                        w_wr_data.chan   = r_chan;
                    end
                    MODE_SETLV: begin
                        w_wr_en   = (w_ent.status != SST_FREE);
                        w_wr_data.level = r_lvl;
                        w_wr_data.slice = 8'd0;
                    end
                    MODE_FREE: begin
                        w_wr_en   = (w_ent.status != SST_FREE);
                        w_wr_data = '0;
                        w_wr_keep = 1'b0;
                    end
                    default: begin
                        w_wr_en = 1'b0;
                    end
                endcase
            end
            S_SCAN: begin
                w_rd_addr = r_idx + IW'(1);
                w_wr_en   = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = w_sc_ent;
                w_wr_keep = (w_ent.status != SST_FREE);
            end
            S_PICK: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_best_ix;
                w_wr_data = w_pick_ent;
            end
            default: begin
                w_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_vld    <= 1'b0;
            r_run_vld    <= 1'b0;
            r_run_slot   <= '0;
            r_now        <= '0;
            r_last_boost <= '0;
            r_last_aging <= '0;
            r_boost_int  <= BOOST_RST;
            r_aging_int  <= AGING_RST;
            r_age_thr    <= AGETH_RST;
            r_lim[0]     <= LIM0_RST;
            r_lim[1]     <= LIM1_RST;
            r_lim[2]     <= LIM2_RST;
            r_lim[3]     <= LIM3_RST;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[4:2])
                    REG_BOOST: r_boost_int <= pwdata[15:0];
                    REG_AGING: r_aging_int <= pwdata[15:0];
                    REG_AGETH: r_age_thr   <= pwdata[15:0];
                    REG_LIM0:  r_lim[0]    <= pwdata[7:0];
                    REG_LIM1:  r_lim[1]    <= pwdata[7:0];
                    REG_LIM2:  r_lim[2]    <= pwdata[7:0];
                    REG_LIM3:  r_lim[3]    <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode     <= t_mode'(i_mode);
                        r_slot     <= i_slot;
                        r_lvl      <= i_level;
                        r_chan     <= i_channel;
                        r_res_st   <= RES_OK;
                        r_res_slot <= '0;
                        r_res_lvl  <= '0;
                        r_res_slc  <= '0;
                        r_res_dem  <= 1'b0;
                        r_res_woke <= '0;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_woke     <= '0;
                        r_state    <= S_EXEC;
                        case (t_mode'(i_mode))
                            MODE_TICK: begin
                                r_now <= r_now + 32'd1;
                                if (!r_run_vld) begin
                                    r_res_st <= RES_NONE;
                                    r_state  <= S_DONE;
                                end
                            end
                            MODE_SCHED: begin
                                if (r_run_vld) begin
                                    r_res_st <= RES_BUSY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_bdue  <= (r_now - r_last_boost) >= {16'd0, r_boost_int};
                                    r_adue  <= (r_now - r_last_aging) >= {16'd0, r_aging_int};
                                    if ((r_now - r_last_boost) >= {16'd0, r_boost_int}) begin
                                        r_last_boost <= r_now;
                                    end
                                    if ((r_now - r_last_aging) >= {16'd0, r_aging_int}) begin
                                        r_last_aging <= r_now;
                                    end
                                    r_state <= S_SCAN;
                                end
                            end
                            MODE_WAKE: begin
                                r_state <= S_SCAN;
                            end
                            MODE_ADMIT, MODE_SETLV: begin
                                if (w_lvl_bad) begin
                                    r_res_st <= RES_LEVEL;
                                    r_state  <= S_DONE;
                                end else if (!w_in_range) begin
                                    r_res_st <= RES_WRONG;
                                    r_state  <= S_DONE;
                                end
                            end
                            MODE_YIELD: begin
                                if (!r_run_vld) begin
                                    r_res_st <= RES_WRONG;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                if (!w_in_range) begin
                                    r_res_st <= RES_WRONG;
                                    r_state  <= S_DONE;
                                end
                            end
                        endcase
                    end
                end
                S_EXEC: begin
                    r_state    <= S_DONE;
                    r_res_slot <= r_slot;
                    r_res_lvl  <= w_ent.level;
                    r_res_slc  <= 8'd0;
                    case (r_mode)
                        MODE_TICK: begin
                            r_res_slot <= 6'(r_run_slot);
                            r_res_lvl  <= w_tk_ent.level;
                            r_res_slc  <= w_tk_ent.slice;
                            r_res_dem  <= w_tk_exp;
                        end
                        MODE_YIELD: begin
                            r_res_slot <= 6'(r_run_slot);
                            r_res_slc  <= w_ent.slice;
                            r_run_vld  <= 1'b0;
                        end
                        MODE_ADMIT: begin
                            r_res_lvl <= r_lvl;
                            if (w_ent.status != SST_FREE) begin
                                r_res_st   <= RES_WRONG;
                                r_res_slot <= '0;
                                r_res_lvl  <= '0;
                            end
                        end
                        MODE_SLEEP: begin
                            if (w_ent.status != SST_RUNNING) begin
                                r_res_st   <= RES_WRONG;
                                r_res_slot <= '0;
                                r_res_lvl  <= '0;
                            end else if (w_match) begin
                                r_run_vld <= 1'b0;
                            end
                        end
                        MODE_SETLV: begin
                            r_res_lvl <= r_lvl;
                            if (w_ent.status == SST_FREE) begin
                                r_res_st   <= RES_WRONG;
                                r_res_slot <= '0;
                                r_res_lvl  <= '0;
                            end
                        end
                        default: begin
                            r_res_lvl <= 2'd0;
                            if (w_ent.status == SST_FREE) begin
                                r_res_st   <= RES_WRONG;
                                r_res_slot <= '0;
                            end else if (w_match) begin
                                r_run_vld <= 1'b0;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    r_idx  <= r_idx + IW'(1);
                    r_woke <= w_woke_nx;
                    if (w_take) begin
                        r_found   <= 1'b1;
                        r_best    <= w_sc_ent;
                        r_best_ix <= r_idx;
                    end
                    if (r_idx == LAST_IX) begin
                        r_state <= S_DONE;
                        if (r_mode == MODE_WAKE) begin
                            r_res_woke <= w_woke_nx;
                        end else if (r_found || w_take) begin
                            r_state <= S_PICK;
                        end else begin
                            r_res_st <= RES_NONE;
                        end
                    end
                end
                S_PICK: begin
                    r_run_vld  <= 1'b1;
                    r_run_slot <= r_best_ix;
                    r_res_slot <= 6'(r_best_ix);
                    r_res_lvl  <= r_best.level;
                    r_res_slc  <= r_best.slice;
                    r_state    <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld <= 1'b1;
                        r_o_st    <= r_res_st;
                        r_o_slot  <= r_res_slot;
                        r_o_lvl   <= r_res_lvl;
                        r_o_slc   <= r_res_slc;
                        r_o_dem   <= r_res_dem;
                        r_o_woke  <= r_res_woke;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_BOOST: prdata = {16'd0, r_boost_int};
            REG_AGING: prdata = {16'd0, r_aging_int};
            REG_AGETH: prdata = {16'd0, r_age_thr};
            REG_LIM0:  prdata = {24'd0, r_lim[0]};
            REG_LIM1:  prdata = {24'd0, r_lim[1]};
            REG_LIM2:  prdata = {24'd0, r_lim[2]};
            REG_LIM3:  prdata = {24'd0, r_lim[3]};
            default:   prdata = 32'd0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_status       = r_o_st;
    assign o_chosen_slot  = r_o_slot;
    assign o_chosen_level = r_o_lvl;
    assign o_chosen_slice = r_o_slc;
    assign o_demoted      = r_o_dem;
    assign o_woken_count  = r_o_woke;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted item left the sequencer idle");

    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_vld |-> (32'(r_run_slot) < SLOT_COUNT))
        else $error("running slot beyond the table");

    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK) |-> (r_found && r_mode == MODE_SCHED))
        else $error("pick without a runnable slot");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_vld) |=> (r_out_vld && r_state == S_IDLE))
        else $error("result not loaded into an empty output register");

endmodule

### hdl/mlfq_tbl.sv
// Slot table: synchronous memory with one read port, one write port and per-entry valid bits.
module mlfq_tbl #(
    parameter int SLOT_COUNT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_rd_addr,
    output mlfq_pkg::t_entry              o_rd_data,
    input  logic                          i_wr_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_wr_addr,
    input  mlfq_pkg::t_entry              i_wr_data,
    input  logic                          i_wr_keep
);
    import mlfq_pkg::*;

    t_entry                  r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]   r_vld;
    t_entry                  r_q;
    logic                    r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_q <= r_mem[i_rd_addr];
    end

    // An entry never written since reset or since it was freed reads as free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= i_wr_keep;
            end
            r_qv <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_qv ? r_q : '0;

endmodule
